@@ design/slcfp_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the sync/length/CRC-8 frame parser.
// Used by slcfp_ctrl, slcfp_datapath and sync_length_crc8_frame_parser; depends on nothing.
`timescale 1ns / 1ps

package slcfp_pkg;

    // Default payload limit and the sync byte value after reset.
    localparam int          MAX_PAYLOAD_DEF = 60;
    localparam logic [7:0]  SYNC_RESET      = 8'd200;

    // CRC-8 (DVB-S2): polynomial 0xD5, initial value zero, MSB first.
    localparam logic [7:0]  CRC_POLY        = 8'hD5;
    localparam logic [7:0]  CRC_INIT        = 8'h00;

    // Shortest legal length byte: the type byte plus the CRC byte.
    localparam logic [7:0]  MIN_LEN         = 8'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_LEN_ERR = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_frame;   // latch the length byte, clear count and CRC
        logic store_byte;    // write a type or payload byte and update the CRC
        logic load_len_err;  // load a length-error result
        logic load_crc_err;  // load a CRC-error result
        logic rd_start;      // rewind the drain pointer
        logic rd_issue;      // read the store at the drain pointer
        logic load_data;     // load the read byte as a result and advance
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sync_hit;      // input byte equals the sync byte
        logic len_ok;        // input byte is a legal length
        logic body_last;     // the byte being stored is the final body byte
        logic crc_ok;        // input byte equals the running CRC
        logic out_free;      // the output register can take a result
        logic drain_last;    // the byte being released is the last one
    } t_dp_sts;

    // One byte of CRC-8, eight shift steps on an 8-bit value.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/slcfp_ctrl.sv @@
// Controller state machine of the frame parser: hunt, length, body, CRC and drain phases.
// Depends on slcfp_pkg; drives commands into slcfp_datapath and reads its status.
`timescale 1ns / 1ps

module slcfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  slcfp_pkg::t_dp_sts i_sts,
    output slcfp_pkg::t_dp_cmd o_cmd
);
    import slcfp_pkg::*;

    typedef enum logic [5:0] {
        S_HUNT = 6'b000001,
        S_LEN  = 6'b000010,
        S_BODY = 6'b000100,
        S_CRC  = 6'b001000,
        S_READ = 6'b010000,
        S_LOAD = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   take;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Length and CRC bytes may cause a result, so they wait for a free output slot.
    always_comb begin
        unique case (r_state)
            S_HUNT, S_BODY: o_in_ready = 1'b1;
            S_LEN, S_CRC:   o_in_ready = i_sts.out_free;
            default:        o_in_ready = 1'b0;
        endcase
    end

    assign take = i_in_valid && o_in_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (take && i_sts.sync_hit) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (take) begin
                    if (i_sts.len_ok) begin
                        o_cmd.start_frame = 1'b1;
                        n_state           = S_BODY;
                    end else begin
                        o_cmd.load_len_err = 1'b1;
                        n_state            = S_HUNT;
                    end
                end
            end
            S_BODY: begin
                if (take) begin
                    o_cmd.store_byte = 1'b1;
                    if (i_sts.body_last) begin
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                if (take) begin
                    if (i_sts.crc_ok) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_READ;
                    end else begin
                        o_cmd.load_crc_err = 1'b1;
                        n_state            = S_HUNT;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_data = 1'b1;
                    n_state         = i_sts.drain_last ? S_HUNT : S_READ;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

endmodule

@@ design/slcfp_datapath.sv @@
// Datapath of the frame parser: sync register, length and count registers, CRC-8,
// frame store memory and the output register. Depends on slcfp_pkg; driven by slcfp_ctrl.
`timescale 1ns / 1ps

module slcfp_datapath #(
    parameter int MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_data,
    input  logic [7:0]         i_rx_byte,
    input  slcfp_pkg::t_dp_cmd i_cmd,
    output slcfp_pkg::t_dp_sts o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_data_byte,
    output logic               o_is_type,
    output logic               o_last,
    output slcfp_pkg::t_status o_status
);
    import slcfp_pkg::*;

    localparam int         STORE_DEPTH = MAX_PAYLOAD + 1;
    localparam int         ADDR_W      = $clog2(STORE_DEPTH);
    localparam int         CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int         LEN_W       = $clog2(MAX_PAYLOAD + 3);
    localparam logic [7:0] LEN_MAX     = 8'(MAX_PAYLOAD + 2);

    logic [7:0]       r_sync_byte;
    logic [LEN_W-1:0] r_frame_length;
    logic [CNT_W-1:0] r_byte_count;
    logic [7:0]       r_crc;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [7:0]       r_rd_data;
    logic [7:0]       r_mem [STORE_DEPTH];

    logic             r_out_valid;
    logic [7:0]       r_data_byte;
    logic             r_is_type;
    logic             r_last;
    t_status          r_status;

    logic [LEN_W:0]   cnt_plus2;

    // Sync byte register, written from the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= SYNC_RESET;
        end else if (i_cfg_valid) begin
            r_sync_byte <= i_cfg_data;
        end
    end

    // Frame length, body count and running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= '0;
            r_byte_count   <= '0;
            r_crc          <= CRC_INIT;
        end else if (i_cmd.start_frame) begin
            r_frame_length <= i_rx_byte[LEN_W-1:0];
            r_byte_count   <= '0;
            r_crc          <= CRC_INIT;
        end else if (i_cmd.store_byte) begin
            r_byte_count   <= r_byte_count + CNT_W'(1);
            r_crc          <= crc8_update(r_crc, i_rx_byte);
        end
    end

    // Frame store: one write port at the body count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            r_mem[r_byte_count[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_cnt[ADDR_W-1:0]];
        end
    end

    // Drain pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt <= '0;
        end else if (i_cmd.rd_start) begin
            r_rd_cnt <= '0;
        end else if (i_cmd.load_data) begin
            r_rd_cnt <= r_rd_cnt + CNT_W'(1);
        end
    end

    // Output register: valid is control, the fields are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_data || i_cmd.load_len_err || i_cmd.load_crc_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_data_byte <= r_rd_data;
            r_is_type   <= (r_rd_cnt == '0);
            r_last      <= o_sts.drain_last;
            r_status    <= ST_GOOD;
        end else if (i_cmd.load_len_err || i_cmd.load_crc_err) begin
            r_data_byte <= 8'd0;
            r_is_type   <= 1'b0;
            r_last      <= 1'b1;
            r_status    <= i_cmd.load_len_err ? ST_LEN_ERR : ST_CRC_ERR;
        end
    end

    // Status towards the controller.
    assign cnt_plus2 = (LEN_W + 1)'(r_byte_count) + (LEN_W + 1)'(2);

    always_comb begin
        o_sts.sync_hit   = (i_rx_byte == r_sync_byte);
        o_sts.len_ok     = (i_rx_byte >= MIN_LEN) && (i_rx_byte <= LEN_MAX);
        o_sts.body_last  = (cnt_plus2 >= {1'b0, r_frame_length});
        o_sts.crc_ok     = (i_rx_byte == r_crc);
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.drain_last = ((r_rd_cnt + CNT_W'(1)) == r_byte_count);
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data_byte;
    assign o_is_type   = r_is_type;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

@@ design/sync_length_crc8_frame_parser.sv @@
// Channel | Dir | Handshake                     | Contents
// s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] rx_byte
// m_axis  | out | m_axis_tvalid / m_axis_tready | tdata data_byte, tlast, tuser is_type/status
// cfg     | in  | i_cfg_valid / o_cfg_ready     | i_cfg_data[7:0] sync byte
//
// Sync and body bytes are taken without waiting; length and CRC bytes are taken when the
// output register is free, otherwise they wait for the pending result to be taken.
// After a good CRC each stored byte is read from the frame store by a registered read and
// then loaded into the output register; no input transfer is taken during that drain.
// Reset is synchronous and active low; the frame store needs no clearing pass.
// Top level of the sync/length/CRC-8 frame parser; depends on slcfp_pkg, slcfp_ctrl
// and slcfp_datapath.
`timescale 1ns / 1ps

module sync_length_crc8_frame_parser #(
    parameter int MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received bytes.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    // Released frame bytes and error results.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast,
    output logic [2:0] m_axis_tuser,   // [0] is_type, [2:1] status
    // Sync byte register write.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import slcfp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    is_type;
    t_status status;

    // The register write is always taken at once.
    assign o_cfg_ready = 1'b1;

    slcfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    slcfp_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_data_byte (m_axis_tdata),
        .o_is_type   (is_type),
        .o_last      (m_axis_tlast),
        .o_status    (status)
    );

    // Pack the flag and the status into tuser, lowest field first.
    assign m_axis_tuser = {status, is_type};

endmodule
